/* hdl/sfhp_pkg.sv */
// Shared constants and status codes for the sniffer frame header parser.
// No dependencies; used by sniffer_frame_header_parser_core.
`default_nettype none

package sfhp_pkg;

    localparam int unsigned POS_W = 17;
    localparam logic [POS_W-1:0] POS_MAX = '1;
    localparam logic [POS_W-1:0] FULL_LEN = 17'd17;
    localparam logic [POS_W-1:0] VERSION_POS_LEN = 17'd4;

    localparam logic [7:0] MARK_HI = 8'hBE;
    localparam logic [7:0] MARK_LO = 8'hEF;

    localparam logic [7:0] HDR_VERSION_1 = 8'd1;
    localparam logic [7:0] HDR_VERSION_2 = 8'd2;

    localparam logic [8:0] LEGACY_HDR_LEN = 9'd8;
    localparam logic [7:0] LEGACY_EVT_LEN = 8'd10;
    localparam logic [8:0] V2_HDR_LEN = 9'd7;

    localparam logic [2:0] PHY_1M = 3'd0;
    localparam logic [2:0] PHY_2M = 3'd1;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_TRUNCATED = 2'd1,
        STATUS_UNKNOWN   = 2'd2,
        STATUS_MISMATCH  = 2'd3
    } status_t;

endpackage

`default_nettype wire

/* hdl/sniffer_frame_header_parser_core.sv */
// Sniffer capture frame header parser: one byte per beat in, one record per frame out.
// Depends on sfhp_pkg for constants and status codes.
// A frame's record is registered in the result register once its last byte leaves the input register.
// Throughput: one byte per cycle; the input register stalls only when it holds
// a last byte and the result register is still full.
// Reset (rst_n, asynchronous): empty pipeline, no previous frame, air time zero.
`default_nettype none

module sniffer_frame_header_parser_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [7:0]          data_byte,
    input  wire logic                last_byte,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [7:0]               version,
    output logic [7:0]               packet_kind,
    output logic [15:0]              uart_counter,
    output logic [15:0]              body_length,
    output logic [7:0]               flag_bits,
    output logic [7:0]               channel_index,
    output logic signed [8:0]        signal_dbm,
    output logic [15:0]              event_count,
    output logic [31:0]              gap_end_start,
    output logic [31:0]              gap_start_start,
    output logic                     gap_valid,
    output logic [1:0]               status
);

    // input register
    logic       s1_valid_reg;
    logic [7:0] s1_data_reg;
    logic       s1_last_reg;
    logic       s1_adv;
    logic       in_accept;

    // frame state
    logic [sfhp_pkg::POS_W-1:0] pos_reg;
    logic [sfhp_pkg::POS_W-1:0] pos_next;
    logic [7:0]  first_byte_reg;
    logic        is_legacy_reg;
    logic [7:0]  hdr_version_reg;
    logic [19:0] prev_air_reg;
    logic [19:0] prev_air_next;
    logic        seen_frame_reg;
    logic [7:0]  frame_bytes_reg [1:16];

    // merged view with the byte being processed
    logic [7:0]  bv [1:16];
    logic [sfhp_pkg::POS_W-1:0] count;
    logic        legacy_v;
    logic [7:0]  hdr_version_v;
    logic        first_is_hi;

    // record fields
    logic [8:0]  hdr_total;
    logic [15:0] pay_total;
    logic [7:0]  evt_len;
    logic [7:0]  kind_c;
    logic [15:0] counter_c;
    logic [31:0] delta_c;
    logic [sfhp_pkg::POS_W-1:0] total_c;
    logic [15:0] air_x;
    logic [2:0]  phy_c;
    logic        has_version;
    sfhp_pkg::status_t status_c;
    logic        full_rec;

    logic        out_valid_reg;
    logic        out_load;

    assign s1_adv    = s1_valid_reg && (!s1_last_reg || !out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign in_accept = in_valid && in_ready;
    assign out_load  = s1_adv && s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_data_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
    end

    // current-frame view of each header byte
    always_comb
    begin
        for (int i = 1; i <= 16; i++)
        begin
            bv[i] = (pos_reg == sfhp_pkg::POS_W'(i)) ? s1_data_reg : frame_bytes_reg[i];
        end
    end

    assign count = (pos_reg != sfhp_pkg::POS_MAX) ? pos_reg + 1'b1 : sfhp_pkg::POS_MAX;
    assign first_is_hi = (first_byte_reg == sfhp_pkg::MARK_HI);

    always_comb
    begin
        priority if (pos_reg == '0)
        begin
            legacy_v = 1'b0;
        end
        else if (pos_reg == sfhp_pkg::POS_W'(1))
        begin
            legacy_v = first_is_hi && (s1_data_reg == sfhp_pkg::MARK_LO);
        end
        else
        begin
            legacy_v = is_legacy_reg;
        end

        priority if (pos_reg == '0)
        begin
            hdr_version_v = 8'd0;
        end
        else if (pos_reg == sfhp_pkg::POS_W'(3) && !legacy_v)
        begin
            hdr_version_v = s1_data_reg;
        end
        else
        begin
            hdr_version_v = hdr_version_reg;
        end
    end

    assign pos_next = s1_last_reg ? '0 : count;

    // header layout decode
    always_comb
    begin
        if (legacy_v)
        begin
            hdr_total = sfhp_pkg::LEGACY_HDR_LEN;
            pay_total = {8'd0, bv[7]};
            evt_len   = sfhp_pkg::LEGACY_EVT_LEN;
            kind_c    = bv[2];
            counter_c = {bv[4], bv[3]};
        end
        else
        begin
            if (hdr_version_v == sfhp_pkg::HDR_VERSION_1)
            begin
                hdr_total = {1'b0, bv[1]} + 9'd1;
                pay_total = {8'd0, bv[2]};
            end
            else
            begin
                hdr_total = sfhp_pkg::V2_HDR_LEN;
                pay_total = {bv[2], bv[1]};
            end
            evt_len   = bv[7];
            kind_c    = bv[6];
            counter_c = {bv[5], bv[4]};
        end
    end

    assign delta_c     = {bv[16], bv[15], bv[14], bv[13]};
    assign total_c     = sfhp_pkg::POS_W'(hdr_total) + sfhp_pkg::POS_W'(pay_total);
    assign air_x       = pay_total - {8'd0, evt_len};
    assign phy_c       = bv[8][6:4];
    assign has_version = (count >= sfhp_pkg::VERSION_POS_LEN) && !legacy_v;

    always_comb
    begin
        full_rec = 1'b0;
        priority if (has_version && hdr_version_v != sfhp_pkg::HDR_VERSION_1
                     && hdr_version_v != sfhp_pkg::HDR_VERSION_2)
        begin
            status_c = sfhp_pkg::STATUS_UNKNOWN;
        end
        else if (count < sfhp_pkg::FULL_LEN)
        begin
            status_c = sfhp_pkg::STATUS_TRUNCATED;
        end
        else
        begin
            full_rec = 1'b1;
            status_c = (total_c != count) ? sfhp_pkg::STATUS_MISMATCH : sfhp_pkg::STATUS_OK;
        end
    end

    always_comb
    begin
        if (!full_rec)
        begin
            prev_air_next = prev_air_reg;
        end
        else if (phy_c == sfhp_pkg::PHY_1M)
        begin
            prev_air_next = {({1'b0, air_x} + 17'd1), 3'b000};
        end
        else if (phy_c == sfhp_pkg::PHY_2M)
        begin
            prev_air_next = {1'b0, ({1'b0, air_x} + 17'd2), 2'b00};
        end
        else
        begin
            prev_air_next = 20'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            first_byte_reg  <= 8'd0;
            is_legacy_reg   <= 1'b0;
            hdr_version_reg <= 8'd0;
            prev_air_reg    <= 20'd0;
            seen_frame_reg  <= 1'b0;
        end
        else if (s1_adv)
        begin
            pos_reg         <= pos_next;
            is_legacy_reg   <= legacy_v;
            hdr_version_reg <= hdr_version_v;
            if (pos_reg == '0)
            begin
                first_byte_reg <= s1_data_reg;
            end
            if (s1_last_reg)
            begin
                prev_air_reg   <= prev_air_next;
                seen_frame_reg <= 1'b1;
            end
        end
    end

    // latch header bytes 1..16 into their lanes
    always_ff @(posedge clk)
    begin
        for (int i = 1; i <= 16; i++)
        begin
            if (s1_adv && pos_reg == sfhp_pkg::POS_W'(i))
            begin
                frame_bytes_reg[i] <= s1_data_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            version <= has_version ? hdr_version_v : 8'd0;
            status  <= status_c;
            if (full_rec)
            begin
                packet_kind     <= kind_c;
                uart_counter    <= counter_c;
                body_length     <= pay_total;
                flag_bits       <= bv[8];
                channel_index   <= bv[9];
                signal_dbm      <= 9'sd0 - $signed({1'b0, bv[10]});
                event_count     <= {bv[12], bv[11]};
                gap_end_start   <= delta_c;
                gap_start_start <= seen_frame_reg ? {12'd0, prev_air_reg} + delta_c : 32'd0;
                gap_valid       <= seen_frame_reg;
            end
            else
            begin
                packet_kind     <= 8'd0;
                uart_counter    <= 16'd0;
                body_length     <= 16'd0;
                flag_bits       <= 8'd0;
                channel_index   <= 8'd0;
                signal_dbm      <= 9'sd0;
                event_count     <= 16'd0;
                gap_end_start   <= 32'd0;
                gap_start_start <= 32'd0;
                gap_valid       <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;

    a_pos_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_last_reg) |=> (pos_reg == '0))
        else $error("byte position not cleared after last beat");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && s1_last_reg && out_valid_reg && !out_ready))
        else $error("input stalled without a blocked record");

    a_rec_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_adv && s1_last_reg))
        else $error("record raised without a last beat");

    a_short_rec_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status == sfhp_pkg::STATUS_TRUNCATED
                           || status == sfhp_pkg::STATUS_UNKNOWN))
        |-> (body_length == 16'd0 && !gap_valid))
        else $error("incomplete record carries fields");

endmodule

`default_nettype wire
